// ----- src/slfs_pkg.sv -----
`timescale 1ns / 1ps

package slfs_pkg;

    localparam int unsigned DUTY_W = 16;
    localparam int unsigned LEN_W  = 12;
    localparam int unsigned RAND_W = 12;
    localparam int unsigned WIDE_W = 17;
    localparam int unsigned DVD_W  = WIDE_W + LEN_W;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_FADE = 2'd1;
    localparam logic [1:0] MODE_PLAY = 2'd2;

    localparam logic [2:0] CFG_ENABLE    = 3'd0;
    localparam logic [2:0] CFG_FADE_LEN  = 3'd1;
    localparam logic [2:0] CFG_PLAY_LEN  = 3'd2;
    localparam logic [2:0] CFG_HOLD      = 3'd3;
    localparam logic [2:0] CFG_DARK      = 3'd4;
    localparam logic [2:0] CFG_DIM       = 3'd5;

    localparam logic [15:0] EVE_TARGET = 16'd500;
    localparam logic [15:0] EVE_MOTION = 16'd20000;
    localparam logic [15:0] EVE_STAIR_A = 16'd4000;
    localparam logic [15:0] EVE_STAIR_B = 16'd2000;
    localparam logic [15:0] NIGHT_TARGET = 16'd70;
    localparam logic [15:0] NIGHT_MOTION = 16'd2500;
    localparam logic [15:0] NIGHT_STAIR_A = 16'd500;
    localparam logic [15:0] NIGHT_STAIR_B = 16'd300;
    localparam logic [15:0] DIM_MOTION = 16'd20000;
    localparam logic [4:0]  EVE_FIRST_HOUR = 5'd6;
    localparam logic [4:0]  EVE_LAST_HOUR  = 5'd22;

    // Reciprocals for the constant divisions: ceil(2^24/5) and ceil(2^20/6).
    localparam logic [21:0] DIV5_MUL = 22'd3355444;
    localparam logic [17:0] DIV6_MUL = 18'd174763;

    typedef struct packed {
        logic [4:0]        hour;
        logic [7:0]        ambient_level;
        logic              motion_edge;
        logic [RAND_W-1:0] rand_a;
        logic [RAND_W-1:0] rand_b;
        logic [RAND_W-1:0] rand_c;
        logic [RAND_W-1:0] rand_d;
        logic [RAND_W-1:0] rand_e;
    } t_in;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_0;
        logic [DUTY_W-1:0] duty_1;
        logic [DUTY_W-1:0] duty_2;
        logic [DUTY_W-1:0] duty_3;
        logic [DUTY_W-1:0] duty_4;
        logic [DUTY_W-1:0] stair_duty_a;
        logic [DUTY_W-1:0] stair_duty_b;
        logic [1:0]        anim_mode;
    } t_out;

    typedef struct packed {
        logic              done;
        logic [WIDE_W-1:0] quot;
    } t_div_res;

    function automatic logic [WIDE_W-1:0] div5(input logic [18:0] x);
        logic [40:0] p;
        p = {22'd0, x} * {19'd0, DIV5_MUL};
        return p[40:24];
    endfunction

    function automatic logic [LEN_W-1:0] div6(input logic [LEN_W-1:0] x);
        logic [31:0] p;
        p = {20'd0, x} * {14'd0, DIV6_MUL};
        return p[31:20];
    endfunction

endpackage

// ----- src/slfs_chan_if.sv -----
`timescale 1ns / 1ps

interface slfs_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/slfs_div.sv -----
`timescale 1ns / 1ps

module slfs_div
    import slfs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [LEN_W-1:0] i_divisor,
    output t_div_res         o_res
);

    // Restoring division, one quotient bit a cycle. The caller guarantees that
    // the quotient fits WIDE_W bits, so the upper dividend bits start as the
    // partial remainder.
    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W-1:0]  r_dvs;
    logic [WIDE_W-1:0] r_sh;
    logic [LEN_W:0]    w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_sh[WIDE_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(WIDE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DVD_W-1:WIDE_W];
            r_sh  <= i_dividend[WIDE_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? LEN_W'(w_trial - {1'b0, r_dvs}) : w_trial[LEN_W-1:0];
            r_sh  <= {r_sh[WIDE_W-2:0], w_ge};
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_sh;

endmodule

// ----- src/staggered_light_fade_sequencer_core.sv -----
`timescale 1ns / 1ps

// Hallway and staircase light sequencer, one tick word in, one duty word out.
// i_in carries a tick word (hour, ambient level, motion edge, random words);
// o_out carries the light duties and the animation mode. Both use valid/ready.
// The configuration port writes a register at each edge with i_cfg_we high;
// write only while the block is idle.
// A word is taken only in the idle state; while the block is disabled a word
// is taken and dropped. Held or steady ticks go straight to the output stage,
// a new fade first shuffles the light order, and fade and breathing ticks run
// each light's interpolation in turn through one shared 17-step restoring
// divider. The result waits in an output register; if the receiver stalls,
// the next word can be taken and computed, and the block holds its finished
// result until the output register frees up.
// After reset the registers hold their defaults (enabled, fade 600, play 1024,
// hold 3000, dark 2, dim 5) and all lights are off.
module staggered_light_fade_sequencer_core
    import slfs_pkg::*;
#(
    parameter int NUM_LIGHTS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slfs_chan_if.sink   i_in,
    slfs_chan_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int IW = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;
    localparam logic [19:0] MOD_MUL = 20'((32'd1048576 + NUM_LIGHTS - 1) / NUM_LIGHTS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SHUF  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_FPREP = 4'd3;
    localparam logic [3:0] S_PH    = 4'd4;
    localparam logic [3:0] S_PL    = 4'd5;
    localparam logic [3:0] S_LSEL  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_POST  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    // Configuration.
    logic              r_enable;
    logic [LEN_W-1:0]  r_fade_len;
    logic [LEN_W-1:0]  r_play_len;
    logic [15:0]       r_hold;
    logic [7:0]        r_dark;
    logic [7:0]        r_dim;

    // Persistent state.
    logic [3:0]        r_state, n_state;
    logic [DUTY_W-1:0] r_cur, n_cur;
    logic [1:0]        r_mode, n_mode;
    logic [DUTY_W-1:0] r_from, n_from;
    logic [DUTY_W-1:0] r_to, n_to;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_step, n_step;
    logic [IW-1:0]     r_order [NUM_LIGHTS];
    logic [IW-1:0]     n_order [NUM_LIGHTS];
    logic [DUTY_W-1:0] r_held [NUM_LIGHTS];
    logic [DUTY_W-1:0] n_held [NUM_LIGHTS];
    logic [15:0]       r_mtimer, n_mtimer;

    // Per-tick work registers.
    logic [RAND_W-1:0] r_rand [NUM_LIGHTS];
    logic [DUTY_W-1:0] r_sa, n_sa;
    logic [DUTY_W-1:0] r_sb, n_sb;
    logic [1:0]        r_amode, n_amode;
    logic [IW-1:0]     r_idx, n_idx;
    logic [LEN_W-1:0]  r_off, n_off;
    logic [LEN_W-1:0]  r_soff, n_soff;
    logic [LEN_W-1:0]  r_span, n_span;
    logic [WIDE_W-1:0] r_high, n_high;
    logic [WIDE_W-1:0] r_low, n_low;
    logic [LEN_W-1:0]  r_fc, n_fc;
    logic              r_rev, n_rev;
    logic [WIDE_W-1:0] r_a, n_a;
    logic              r_neg, n_neg;
    logic [DVD_W-1:0]  r_dividend, n_dividend;
    logic              r_div_start, n_div_start;

    logic              r_out_valid;
    t_out              r_out;

    t_div_res          w_div;
    logic              w_accept;
    logic              w_out_load;
    logic [RAND_W-1:0] w_rand_in [5];

    slfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_dividend),
        .i_divisor  (r_span),
        .o_res      (w_div)
    );

    assign i_in.ready   = (r_state == S_IDLE);
    assign w_accept     = i_in.valid && (r_state == S_IDLE);
    assign w_out_load   = (r_state == S_FIN) && (!r_out_valid || o_out.ready);
    assign o_out.valid  = r_out_valid;
    assign o_out.data   = r_out;

    assign w_rand_in[0] = i_in.data.rand_a;
    assign w_rand_in[1] = i_in.data.rand_b;
    assign w_rand_in[2] = i_in.data.rand_c;
    assign w_rand_in[3] = i_in.data.rand_d;
    assign w_rand_in[4] = i_in.data.rand_e;

    // Band selection and motion override for the incoming tick.
    logic [DUTY_W-1:0] w_target, w_mlvl, w_sa, w_sb, w_tgt;
    logic [15:0]       w_mt0, w_mt;
    always_comb begin
        if (i_in.data.ambient_level < r_dark) begin
            if (i_in.data.hour >= EVE_FIRST_HOUR && i_in.data.hour <= EVE_LAST_HOUR) begin
                w_target = EVE_TARGET;
                w_mlvl   = EVE_MOTION;
                w_sa     = EVE_STAIR_A;
                w_sb     = EVE_STAIR_B;
            end else begin
                w_target = NIGHT_TARGET;
                w_mlvl   = NIGHT_MOTION;
                w_sa     = NIGHT_STAIR_A;
                w_sb     = NIGHT_STAIR_B;
            end
        end else if (i_in.data.ambient_level < r_dim) begin
            w_target = '0;
            w_mlvl   = DIM_MOTION;
            w_sa     = '0;
            w_sb     = '0;
        end else begin
            w_target = '0;
            w_mlvl   = '0;
            w_sa     = '0;
            w_sb     = '0;
        end
        w_mt0 = i_in.data.motion_edge ? r_hold : r_mtimer;
        if (w_mt0 != 16'd0) begin
            w_tgt = w_mlvl;
            w_mt  = w_mt0 - 16'd1;
        end else begin
            w_tgt = w_target;
            w_mt  = w_mt0;
        end
    end

    // Shuffle index: random word modulo the light count by reciprocal.
    logic [32:0]       w_mod_p;
    logic [RAND_W-1:0] w_mod_q;
    logic [RAND_W-1:0] w_mod_r;
    logic [IW-1:0]     w_j;
    assign w_mod_p = {21'd0, r_rand[r_idx]} * {13'd0, MOD_MUL};
    assign w_mod_q = w_mod_p[31:20];
    assign w_mod_r = RAND_W'(r_rand[r_idx] - RAND_W'(w_mod_q * RAND_W'(NUM_LIGHTS)));
    assign w_j     = w_mod_r[IW-1:0];

    // Per-light interpolation setup.
    logic [LEN_W:0]    w_s;
    logic [LEN_W-1:0]  w_sval;
    logic              w_up;
    logic [WIDE_W-1:0] w_la, w_lb, w_mag;
    logic [LEN_W-1:0]  w_half;
    logic [WIDE_W-1:0] w_qres;
    assign w_s    = {1'b0, r_step} - {1'b0, r_soff};
    assign w_half = {1'b0, r_len[LEN_W-1:1]};
    assign w_up   = r_idx[0] ^ r_rev;
    assign w_qres = r_neg ? (r_a - w_div.quot) : (r_a + w_div.quot);

    always_comb begin
        if (r_amode == MODE_FADE) begin
            w_la   = {1'b0, r_from};
            w_lb   = {1'b0, r_to};
            w_sval = w_s[LEN_W-1:0];
        end else begin
            w_la   = w_up ? r_low : r_high;
            w_lb   = w_up ? r_high : r_low;
            w_sval = r_fc;
        end
        w_mag = (w_lb >= w_la) ? (w_lb - w_la) : (w_la - w_lb);
    end

    logic              w_wr;
    logic [DUTY_W-1:0] w_wr_val;
    logic              w_next_light;

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_mode      = r_mode;
        n_from      = r_from;
        n_to        = r_to;
        n_len       = r_len;
        n_step      = r_step;
        n_order     = r_order;
        n_held      = r_held;
        n_mtimer    = r_mtimer;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_amode     = r_amode;
        n_idx       = r_idx;
        n_off       = r_off;
        n_soff      = r_soff;
        n_span      = r_span;
        n_high      = r_high;
        n_low       = r_low;
        n_fc        = r_fc;
        n_rev       = r_rev;
        n_a         = r_a;
        n_neg       = r_neg;
        n_dividend  = r_dividend;
        n_div_start = 1'b0;
        w_wr        = 1'b0;
        w_wr_val    = r_from;
        w_next_light = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && r_enable) begin
                    n_mtimer = w_mt;
                    n_sa     = w_sa;
                    n_sb     = w_sb;
                    n_state  = S_DISP;
                    if (w_tgt != r_cur) begin
                        if (r_mode == MODE_FADE) begin
                            n_step = r_len - r_step;
                            n_from = r_to;
                            n_to   = r_from;
                        end else begin
                            n_mode = MODE_FADE;
                            n_step = '0;
                            n_from = r_cur;
                            n_to   = w_tgt;
                            n_len  = r_fade_len;
                            for (int k = 0; k < NUM_LIGHTS; k++) n_order[k] = IW'(k);
                            n_idx   = '0;
                            n_state = S_SHUF;
                        end
                        n_cur = w_tgt;
                    end
                end
            end
            S_SHUF: begin
                n_order[r_idx] = r_order[w_j];
                n_order[w_j]   = r_order[r_idx];
                if (r_idx == IW'(NUM_LIGHTS - 1)) begin
                    n_state = S_DISP;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_DISP: begin
                if (r_mode == MODE_FADE) begin
                    if (r_step >= r_len) begin
                        n_mode  = MODE_NONE;
                        n_amode = MODE_NONE;
                        n_state = S_FIN;
                    end else begin
                        n_off   = div6(r_len);
                        n_amode = MODE_FADE;
                        n_state = S_FPREP;
                    end
                end else if (r_mode == MODE_PLAY) begin
                    n_amode = MODE_PLAY;
                    if (w_half == '0) begin
                        for (int k = 0; k < NUM_LIGHTS; k++) n_held[k] = r_from;
                        n_step  = '0;
                        n_state = S_FIN;
                    end else begin
                        n_span  = w_half;
                        n_state = S_PH;
                    end
                end else begin
                    // Steady tick: show the level, then breathe from the next tick.
                    for (int k = 0; k < NUM_LIGHTS; k++) begin
                        n_held[k]  = r_cur;
                        n_order[k] = IW'(k);
                    end
                    n_mode  = MODE_PLAY;
                    n_step  = {2'd0, r_play_len[LEN_W-1:2]};
                    n_from  = r_cur;
                    n_len   = r_play_len;
                    n_amode = MODE_NONE;
                    n_state = S_FIN;
                end
            end
            S_FPREP: begin
                n_span  = LEN_W'(r_len - LEN_W'(r_off * LEN_W'(NUM_LIGHTS)));
                n_soff  = '0;
                n_idx   = '0;
                n_state = S_LSEL;
            end
            S_PH: begin
                n_high  = div5(({3'd0, r_from} << 3) - {3'd0, r_from});
                n_state = S_PL;
            end
            S_PL: begin
                n_low = div5(({3'd0, r_from} << 1) + {3'd0, r_from});
                n_rev = r_step >= w_half;
                if (r_step >= (w_half << 1)) begin
                    n_fc = r_step - (w_half << 1);
                end else if (r_step >= w_half) begin
                    n_fc = r_step - w_half;
                end else begin
                    n_fc = r_step;
                end
                n_idx   = '0;
                n_state = S_LSEL;
            end
            S_LSEL: begin
                if (r_amode == MODE_FADE && w_s[LEN_W]) begin
                    w_wr         = 1'b1;
                    w_wr_val     = r_from;
                    w_next_light = 1'b1;
                end else if (r_amode == MODE_FADE && (r_span == '0 || w_sval > r_span)) begin
                    w_wr         = 1'b1;
                    w_wr_val     = r_to;
                    w_next_light = 1'b1;
                end else begin
                    n_a         = w_la;
                    n_neg       = w_lb < w_la;
                    n_dividend  = DVD_W'(w_mag * DVD_W'(w_sval));
                    n_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    w_wr         = 1'b1;
                    w_wr_val     = w_qres[DUTY_W-1:0];
                    w_next_light = 1'b1;
                end
            end
            S_POST: begin
                if (r_amode == MODE_FADE) begin
                    n_step = r_step + LEN_W'(1);
                end else begin
                    n_step = (r_step + LEN_W'(1) == r_len) ? '0 : r_step + LEN_W'(1);
                    // Light 2 stays at the base level while the others breathe.
                    for (int k = 0; k < NUM_LIGHTS; k++) begin
                        if (k == 2) n_held[k] = r_from;
                    end
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (w_wr) n_held[r_order[r_idx]] = w_wr_val;
        if (w_next_light) begin
            n_soff = r_soff + r_off;
            if (r_idx == IW'(NUM_LIGHTS - 1)) begin
                n_state = S_POST;
            end else begin
                n_idx   = r_idx + IW'(1);
                n_state = S_LSEL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b1;
            r_fade_len  <= 12'd600;
            r_play_len  <= 12'd1024;
            r_hold      <= 16'd3000;
            r_dark      <= 8'd2;
            r_dim       <= 8'd5;
            r_cur       <= '0;
            r_mode      <= MODE_NONE;
            r_from      <= '0;
            r_to        <= '0;
            r_len       <= '0;
            r_step      <= '0;
            r_mtimer    <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_LIGHTS; k++) begin
                r_order[k] <= IW'(k);
                r_held[k]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_mode      <= n_mode;
            r_from      <= n_from;
            r_to        <= n_to;
            r_len       <= n_len;
            r_step      <= n_step;
            r_order     <= n_order;
            r_held      <= n_held;
            r_mtimer    <= n_mtimer;
            r_div_start <= n_div_start;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ENABLE:   r_enable   <= i_cfg_data[0];
                    CFG_FADE_LEN: r_fade_len <= i_cfg_data[LEN_W-1:0];
                    CFG_PLAY_LEN: r_play_len <= i_cfg_data[LEN_W-1:0];
                    CFG_HOLD:     r_hold     <= i_cfg_data;
                    CFG_DARK:     r_dark     <= i_cfg_data[7:0];
                    CFG_DIM:      r_dim      <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int k = 0; k < NUM_LIGHTS; k++) r_rand[k] <= w_rand_in[k];
        end
        r_sa       <= n_sa;
        r_sb       <= n_sb;
        r_amode    <= n_amode;
        r_idx      <= n_idx;
        r_off      <= n_off;
        r_soff     <= n_soff;
        r_span     <= n_span;
        r_high     <= n_high;
        r_low      <= n_low;
        r_fc       <= n_fc;
        r_rev      <= n_rev;
        r_a        <= n_a;
        r_neg      <= n_neg;
        r_dividend <= n_dividend;
    end

    // Absent lights read as dark.
    logic [DUTY_W-1:0] w_duty [5];
    for (genvar g = 0; g < 5; g++) begin : g_duty
        if (g < NUM_LIGHTS) begin : g_on
            assign w_duty[g] = r_held[g];
        end else begin : g_off
            assign w_duty[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.duty_0       <= w_duty[0];
            r_out.duty_1       <= w_duty[1];
            r_out.duty_2       <= w_duty[2];
            r_out.duty_3       <= w_duty[3];
            r_out.duty_4       <= w_duty[4];
            r_out.stair_duty_a <= r_sa;
            r_out.stair_duty_b <= r_sb;
            r_out.anim_mode    <= r_amode;
        end
    end

    a_div_start_enters_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> r_state == S_DIV)
        else $error("divider started outside the wait state");

    a_fin_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !o_out.ready) |=> r_state == S_FIN)
        else $error("finished word overwrote a stalled result");

    a_play_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_mode == MODE_PLAY && r_len != '0) |-> r_step < r_len)
        else $error("breathing step counter out of range");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import slfs_pkg::*;

    localparam int LIGHTS = 5;
    localparam longint CYCLE_LIMIT = 3000000;

    class light_scoreboard;
        int unsigned en, fade_len, play_len, hold_ticks, dark_lvl, dim_lvl;
        int          cur_level, anim, lvl_from, lvl_to, len, step, motion_left;
        int          order[LIGHTS];
        int          held[LIGHTS];
        t_out        duty_q[$];
        int          errors;

        function void reset_state();
            en = 1; fade_len = 600; play_len = 1024; hold_ticks = 3000;
            dark_lvl = 2; dim_lvl = 5;
            cur_level = 0; anim = MODE_NONE; lvl_from = 0; lvl_to = 0;
            len = 0; step = 0; motion_left = 0;
            foreach (order[i]) order[i] = i;
            foreach (held[i]) held[i] = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_ENABLE:   en = val[0];
                CFG_FADE_LEN: fade_len = val[11:0];
                CFG_PLAY_LEN: play_len = val[11:0];
                CFG_HOLD:     hold_ticks = val;
                CFG_DARK:     dark_lvl = val[7:0];
                CFG_DIM:      dim_lvl = val[7:0];
                default: ;
            endcase
        endfunction

        function int interp(int st, int a, int b, int span);
            if (st < 0) return a;
            if (st > span || span <= 0) return b;
            return a + ((b - a) * st) / span;
        endfunction

        // Predicts the duty word caused by one accepted tick word.
        function void note_tick(t_in d);
            int target, motion_lvl, sa, sb, amode, off, span, half, base, hi, lo, fc, j, t;
            int rnd[LIGHTS];
            bit rev, up;
            t_out r;
            if (!en) return;
            rnd = '{d.rand_a, d.rand_b, d.rand_c, d.rand_d, d.rand_e};
            amode = MODE_NONE;
            if (d.ambient_level < dark_lvl) begin
                if (d.hour >= EVE_FIRST_HOUR && d.hour <= EVE_LAST_HOUR) begin
                    target = 500; motion_lvl = 20000; sa = 4000; sb = 2000;
                end else begin
                    target = 70; motion_lvl = 2500; sa = 500; sb = 300;
                end
            end else if (d.ambient_level < dim_lvl) begin
                target = 0; motion_lvl = 20000; sa = 0; sb = 0;
            end else begin
                target = 0; motion_lvl = 0; sa = 0; sb = 0;
            end
            if (d.motion_edge) motion_left = hold_ticks;
            if (motion_left != 0) begin
                target = motion_lvl;
                motion_left--;
            end
            if (target != cur_level) begin
                if (anim == MODE_FADE) begin
                    // A running fade turns around from where it stands.
                    step = (len - step) & 12'hFFF;
                    t = lvl_from; lvl_from = lvl_to; lvl_to = t;
                end else begin
                    anim = MODE_FADE; step = 0;
                    lvl_from = cur_level; lvl_to = target; len = fade_len;
                    foreach (order[i]) order[i] = i;
                    for (int i = 0; i < LIGHTS; i++) begin
                        j = rnd[i] % LIGHTS;
                        t = order[i]; order[i] = order[j]; order[j] = t;
                    end
                end
                cur_level = target;
            end
            if (anim == MODE_FADE) begin
                if (step >= len) begin
                    anim = MODE_NONE;
                end else begin
                    off = len / 6;
                    span = len - LIGHTS * off;
                    for (int i = 0; i < LIGHTS; i++)
                        held[order[i]] = interp(step - off * i, lvl_from, lvl_to, span);
                    step = (step + 1) & 12'hFFF;
                    amode = MODE_FADE;
                end
            end else if (anim == MODE_PLAY) begin
                amode = MODE_PLAY;
                half = len / 2;
                base = lvl_from;
                hi = base * 7 / 5;
                lo = base * 3 / 5;
                if (half == 0) begin
                    foreach (held[i]) held[i] = base;
                    step = 0;
                end else begin
                    rev = step >= half;
                    fc = step % half;
                    for (int i = 0; i < LIGHTS; i++) begin
                        up = ((i % 2) != 0) ^ rev;
                        held[order[i]] = interp(fc, up ? lo : hi, up ? hi : lo, half);
                    end
                    step = (step + 1) % len;
                    held[2] = base;
                end
            end else begin
                foreach (held[i]) held[i] = cur_level;
                anim = MODE_PLAY;
                step = play_len / 4;
                lvl_from = cur_level;
                len = play_len;
                foreach (order[i]) order[i] = i;
            end
            r.duty_0 = 16'(held[0]); r.duty_1 = 16'(held[1]); r.duty_2 = 16'(held[2]);
            r.duty_3 = 16'(held[3]); r.duty_4 = 16'(held[4]);
            r.stair_duty_a = 16'(sa); r.stair_duty_b = 16'(sb);
            r.anim_mode = 2'(amode);
            duty_q.push_back(r);
        endfunction

        function void cmp(string name, int e, int a);
            if (e != a) begin
                $error("%s expected %0d actual %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_duty(t_out a);
            t_out e;
            if (duty_q.size() == 0) begin
                $error("duty word arrived with none expected");
                errors++;
                return;
            end
            e = duty_q.pop_front();
            cmp("duty_0", e.duty_0, a.duty_0);
            cmp("duty_1", e.duty_1, a.duty_1);
            cmp("duty_2", e.duty_2, a.duty_2);
            cmp("duty_3", e.duty_3, a.duty_3);
            cmp("duty_4", e.duty_4, a.duty_4);
            cmp("stair_duty_a", e.stair_duty_a, a.stair_duty_a);
            cmp("stair_duty_b", e.stair_duty_b, a.stair_duty_b);
            cmp("anim_mode", e.anim_mode, a.anim_mode);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = CFG_ENABLE;
    logic [15:0] i_cfg_data = '0;

    slfs_chan_if #(.T(t_in))  in_if ();
    slfs_chan_if #(.T(t_out)) out_if ();

    light_scoreboard sb = new();
    longint cycles = 0;
    int     words_out = 0;
    bit     no_idle = 1'b0;
    int     cur_hour = 8;
    int     cur_amb = 0;

    staggered_light_fade_sequencer_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("staggered_light_fade_sequencer_core regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_duty(out_if.data);
            words_out <= words_out + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random stalls, plus one long hold-off that backs the block up.
    initial begin
        bit long_done;
        int gap;
        long_done = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = pick_gap();
            if (!long_done && words_out >= 300) begin
                long_done = 1'b1;
                gap = 3000;
            end
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            repeat ($urandom_range(1, 25)) @(posedge i_clk);
        end
    end

    task automatic set_regs(int en, int fl, int pl, int hold, int dark, int dim);
        logic [15:0] vals[6];
        logic [2:0]  idx[6];
        vals = '{16'(en), 16'(fl), 16'(pl), 16'(hold), 16'(dark), 16'(dim)};
        idx = '{CFG_ENABLE, CFG_FADE_LEN, CFG_PLAY_LEN, CFG_HOLD, CFG_DARK, CFG_DIM};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.write_reg(idx[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_tick(int hour, int amb, bit motion, logic [59:0] rnd);
        t_in d;
        int gap;
        d.hour = 5'(hour);
        d.ambient_level = 8'(amb);
        d.motion_edge = motion;
        {d.rand_a, d.rand_b, d.rand_c, d.rand_d, d.rand_e} = rnd;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= d;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_tick(d);
    endtask

    function automatic logic [59:0] rand_words();
        return 60'({$urandom(), $urandom()});
    endfunction

    // Waits out all expected words and any disabled word still in flight.
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.duty_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Ambient and hour mostly stay put so fades can run to their end.
    task automatic random_ticks(int count);
        int r;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) cur_hour = $urandom_range(0, 23);
            if ($urandom_range(0, 9) == 0) begin
                r = $urandom_range(0, 2);
                if (r == 0 && sb.dark_lvl > 0)
                    cur_amb = $urandom_range(0, sb.dark_lvl - 1);
                else if (r == 1 && sb.dim_lvl > sb.dark_lvl)
                    cur_amb = $urandom_range(sb.dark_lvl, sb.dim_lvl - 1);
                else
                    cur_amb = $urandom_range(0, 255);
            end
            send_tick(cur_hour, cur_amb, $urandom_range(0, 19) == 0, rand_words());
        end
    endtask

    initial begin
        sb.reset_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bands and hour edges at reset settings, then a motion edge.
        send_tick(6, 0, 0, '0);
        send_tick(22, 0, 0, '1);
        send_tick(23, 1, 0, rand_words());
        send_tick(0, 0, 0, rand_words());
        send_tick(5, 0, 0, rand_words());
        send_tick(12, 3, 0, rand_words());
        send_tick(12, 4, 0, rand_words());
        send_tick(16, 255, 0, rand_words());
        send_tick(23, 255, 0, '1);
        send_tick(12, 2, 0, rand_words());
        send_tick(8, 0, 1, rand_words());
        send_tick(8, 255, 0, rand_words());
        drain();

        // Short fade and play, no motion hold.
        set_regs(1, 12, 4, 0, 128, 200);
        for (int i = 0; i < 8; i++) send_tick(7, 0, i == 2, rand_words());
        random_ticks(150);
        drain();

        // Zero fade length and a degenerate play length.
        set_regs(1, 0, 1, 1, 255, 0);
        random_ticks(120);
        drain();

        // Odd play length, motion hold of two.
        set_regs(1, 13, 7, 2, 40, 90);
        random_ticks(150);
        drain();

        // Disabled: words are dropped, edges ignored.
        set_regs(0, 20, 10, 5, 255, 255);
        random_ticks(40);
        drain();

        // Largest fade length, hold and thresholds, play length just below its maximum.
        set_regs(1, 4095, 4094, 65535, 255, 255);
        random_ticks(100);
        drain();
        set_regs(1, 600, 1024, 3000, 0, 0);
        random_ticks(30);
        drain();

        for (int p = 0; p < 6; p++) begin
            set_regs(1, $urandom_range(12, 60), $urandom_range(0, 40),
                     $urandom_range(0, 40), $urandom_range(0, 255), $urandom_range(0, 255));
            no_idle = (p == 2);
            random_ticks(230);
            drain();
        end
        no_idle = 1'b0;

        if (sb.errors == 0)
            $display("staggered_light_fade_sequencer_core regression: pass");
        else
            $display("staggered_light_fade_sequencer_core regression: fail");
        $finish;
    end
endmodule

// ----- files.f -----
src/slfs_pkg.sv
src/slfs_chan_if.sv
src/slfs_div.sv
src/staggered_light_fade_sequencer_core.sv
verif/tb.sv
